// ----- sv/sle_pkg.sv -----
// sle_pkg: shared types and constants of the sorted list engine
// depends on nothing; used by sle_cell, sorted_list_engine and tb_sorted_list_engine
package sle_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int VAL_W        = 32;
    localparam int CMD_W        = 3;
    localparam int POS_W        = 4;
    localparam int STAT_W       = 3;
    localparam int CNT_OUT_W    = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_GET    = 3'd2,
        CMD_FIND   = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // per-cycle control broadcast to every cell of the chain
    typedef struct packed {
        logic cap;   // register compare flags against the incoming value
        logic ins;   // shift towards the tail and drop the new value in
        logic rem;   // shift towards the head over the matching entry
    } t_cell_ctl;

endpackage

// ----- sv/sle_cell.sv -----
// sle_cell: one entry of the sorted chain with its compare flags
// depends on sle_pkg
module sle_cell import sle_pkg::*; (
    input  logic                    i_clk,
    input  t_cell_ctl               i_ctl,
    input  logic                    i_in_range,
    input  logic signed [VAL_W-1:0] i_cmp_value,
    input  logic signed [VAL_W-1:0] i_ins_value,
    input  logic signed [VAL_W-1:0] i_prev_data,
    input  logic                    i_prev_lt,
    input  logic signed [VAL_W-1:0] i_next_data,
    output logic signed [VAL_W-1:0] o_data,
    output logic                    o_lt,
    output logic                    o_eq
);

    logic signed [VAL_W-1:0] r_data;
    logic                    r_lt;
    logic                    r_eq;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_lt <= i_in_range && (r_data < i_cmp_value);
            r_eq <= i_in_range && (r_data == i_cmp_value);
        end
        // entries smaller than the value never move
        if (i_ctl.ins && !r_lt) begin
            r_data <= i_prev_lt ? i_ins_value : i_prev_data;
        end else if (i_ctl.rem && !r_lt) begin
            r_data <= i_next_data;
        end
    end

    assign o_data = r_data;
    assign o_lt   = r_lt;
    assign o_eq   = r_eq;

endmodule

// ----- sv/sorted_list_engine.sv -----
// sorted_list_engine: ascending list of signed words held in a chain of cells
// depends on sle_pkg and sle_cell
//
//  channel   direction  valid     stall     payload
//  command   in         i_valid   o_stall   i_command, i_value, i_position
//  result    out        o_valid   i_stall   o_status, o_read_value, o_found,
//                                           o_count, o_full_res, o_empty_res
//
// a request is accepted only in idle: the accept edge registers the compare
// flags of all cells; in execute the chain shifts and the result register loads.
// a stalled result holds the engine in its execute state.
// reset clears the count and the handshake state only; entry contents are
// not reset. no sweep after reset.
module sorted_list_engine import sle_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [CMD_W-1:0]         i_command,
    input  logic signed [VAL_W-1:0]  i_value,
    input  logic [POS_W-1:0]         i_position,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [VAL_W-1:0]  o_read_value,
    output logic                     o_found,
    output logic [CNT_OUT_W-1:0]     o_count,
    output logic                     o_full_res,
    output logic                     o_empty_res
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int RD  = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);
    localparam int RDW = $clog2(RD);
    localparam int PW  = (CW > POS_W) ? CW : POS_W;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [CMD_W-1:0]        r_cmd;
    logic signed [VAL_W-1:0] r_value;
    logic [POS_W-1:0]        r_pos;

    logic                    r_out_valid;
    logic [STAT_W-1:0]       r_status, n_status;
    logic signed [VAL_W-1:0] r_rd, n_rd;
    logic                    r_found, n_found;
    logic                    r_full, r_empty;

    t_cell_ctl               w_ctl;
    logic                    w_accept, w_go, w_ins, w_rem;
    logic                    w_match, w_pos_ok;
    logic [CAPACITY-1:0]     w_lt, w_eq, w_hit, w_in_range, w_prev_lt;
    logic signed [VAL_W-1:0] w_data [CAPACITY];
    logic signed [VAL_W-1:0] w_low  [RD];

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_go     = (r_state == S_EXEC) && (!r_out_valid || !i_stall);

    assign w_ctl.cap = w_accept;
    assign w_ctl.ins = w_go && w_ins;
    assign w_ctl.rem = w_go && w_rem;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            assign w_in_range[g] = (CW'(g) < r_count);
            if (g == 0) begin : g_head
                assign w_prev_lt[g] = 1'b1;
            end else begin : g_body
                assign w_prev_lt[g] = w_lt[g-1];
            end
            sle_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_in_range  (w_in_range[g]),
                .i_cmp_value (i_value),
                .i_ins_value (r_value),
                .i_prev_data ((g == 0) ? r_value : w_data[(g == 0) ? 0 : g-1]),
                .i_prev_lt   (w_prev_lt[g]),
                .i_next_data (w_data[(g == CAPACITY-1) ? g : g+1]),
                .o_data      (w_data[g]),
                .o_lt        (w_lt[g]),
                .o_eq        (w_eq[g])
            );
            // the first entry that is not smaller is the only removal candidate
            assign w_hit[g] = w_eq[g] && !w_lt[g] && w_prev_lt[g];
        end
        for (g = 0; g < RD; g++) begin : g_low
            assign w_low[g] = w_data[g];
        end
    endgenerate

    assign w_match  = |w_hit;
    assign w_pos_ok = (PW'(r_pos) < PW'(r_count)) && (PW'(r_pos) < PW'(RD));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_command;
            r_value <= i_value;
            r_pos   <= i_position;
        end
        if (w_go) begin
            r_status <= n_status;
            r_rd     <= n_rd;
            r_found  <= n_found;
            r_full   <= (n_count == CW'(CAPACITY));
            r_empty  <= (n_count == '0);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_status = ST_OK;
        n_rd     = '0;
        n_found  = 1'b0;
        w_ins    = 1'b0;
        w_rem    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_go) begin
                    n_state = S_IDLE;
                end
                case (r_cmd)
                    CMD_INSERT: begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else begin
                            w_ins   = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end
                    CMD_REMOVE: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else if (w_match) begin
                            w_rem   = 1'b1;
                            n_count = r_count - 1'b1;
                        end else begin
                            n_status = ST_NOTFOUND;
                        end
                    end
                    CMD_GET: begin
                        if (w_pos_ok) begin
                            n_rd = w_low[r_pos[RDW-1:0]];
                        end else begin
                            n_status = ST_BADPOS;
                            n_rd     = '1;
                        end
                    end
                    CMD_FIND: begin
                        n_found = |w_eq;
                    end
                    CMD_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_read_value = r_rd;
    assign o_found      = r_found;
    assign o_count      = CNT_OUT_W'(r_count);
    assign o_full_res   = r_full;
    assign o_empty_res  = r_empty;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("count beyond capacity");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted request did not reach execute");

    a_lt_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> (((w_lt >> 1) & ~w_lt) == '0))
        else $error("chain lost ascending order");

    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the list");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> o_full_res)
        else $error("full status with list not full");

endmodule

// ----- dv/tb_sorted_list_engine.sv -----
`timescale 1ns / 1ps
// tb_sorted_list_engine: self-checking bench for the sorted list engine
// depends on sle_pkg and sorted_list_engine; checks results against a shadow list or typed rows
module tb_sorted_list_engine;
    import sle_pkg::*;

    localparam int LIST_CAP     = DEF_CAPACITY;
    localparam int RAND_BLOCKS  = 27;
    localparam int BLOCK_LEN    = 60;
    localparam int MAX_IDLE     = 17;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    localparam logic [VAL_W-1:0] VAL_MIN   = 32'h8000_0000;
    localparam logic [VAL_W-1:0] VAL_MAX   = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] READ_MISS = '1;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [VAL_W-1:0]     read_value;
        logic                 found;
        logic [CNT_OUT_W-1:0] count;
        logic                 full_res;
        logic                 empty_res;
    } t_list_result;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] pos;
        logic             typed;
        t_list_result     res;
    } t_list_row;

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_valid      = 1'b0;
    logic [CMD_W-1:0]        i_command    = '0;
    logic signed [VAL_W-1:0] i_value      = '0;
    logic [POS_W-1:0]        i_position   = '0;
    logic                    i_stall      = 1'b0;
    logic                    o_stall;
    logic                    o_valid;
    logic [STAT_W-1:0]       o_status;
    logic signed [VAL_W-1:0] o_read_value;
    logic                    o_found;
    logic [CNT_OUT_W-1:0]    o_count;
    logic                    o_full_res;
    logic                    o_empty_res;

    logic signed [VAL_W-1:0] shadow_list [LIST_CAP];
    int                      shadow_cnt = 0;
    t_list_result            pending_results [$];
    int                      fail_count = 0;
    bit                      rx_calm = 1'b0;

    sorted_list_engine #(
        .CAPACITY(LIST_CAP)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_value     (i_value),
        .i_position  (i_position),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_read_value(o_read_value),
        .o_found     (o_found),
        .o_count     (o_count),
        .o_full_res  (o_full_res),
        .o_empty_res (o_empty_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("tb_sorted_list_engine: FAIL");
        $finish;
    end

    // applies one request to the shadow list and returns what the engine should report
    function automatic t_list_result apply_to_shadow(input logic [CMD_W-1:0] cmd,
            input logic signed [VAL_W-1:0] v, input logic [POS_W-1:0] pos);
        t_list_result r;
        int slot;
        int k;
        r = '0;
        r.status = ST_OK;
        slot = 0;
        while (slot < shadow_cnt && shadow_list[slot] < v) slot++;
        case (cmd)
            CMD_INSERT: begin
                if (shadow_cnt >= LIST_CAP) begin
                    r.status = ST_FULL;
                end else begin
                    for (k = shadow_cnt; k > slot; k--) shadow_list[k] = shadow_list[k-1];
                    shadow_list[slot] = v;
                    shadow_cnt++;
                end
            end
            CMD_REMOVE: begin
                if (shadow_cnt == 0) begin
                    r.status = ST_EMPTY;
                end else if (slot < shadow_cnt && shadow_list[slot] == v) begin
                    for (k = slot + 1; k < shadow_cnt; k++) shadow_list[k-1] = shadow_list[k];
                    shadow_cnt--;
                end else begin
                    r.status = ST_NOTFOUND;
                end
            end
            CMD_GET: begin
                if (int'(pos) < shadow_cnt) begin
                    r.read_value = shadow_list[pos];
                end else begin
                    r.status     = ST_BADPOS;
                    r.read_value = READ_MISS;
                end
            end
            CMD_FIND: begin
                // lower bound lands on the first equal entry if there is one
                r.found = (slot < shadow_cnt && shadow_list[slot] == v);
            end
            CMD_CLEAR: begin
                shadow_cnt = 0;
            end
            default: begin
            end
        endcase
        r.count     = CNT_OUT_W'(shadow_cnt);
        r.full_res  = (shadow_cnt == LIST_CAP);
        r.empty_res = (shadow_cnt == 0);
        return r;
    endfunction

    function automatic t_list_result typed_res(input logic [STAT_W-1:0] st,
            input logic [VAL_W-1:0] rd, input logic fnd, input int cnt);
        t_list_result r;
        r.status     = st;
        r.read_value = rd;
        r.found      = fnd;
        r.count      = CNT_OUT_W'(cnt);
        r.full_res   = (cnt == LIST_CAP);
        r.empty_res  = (cnt == 0);
        return r;
    endfunction

    function automatic t_list_row mk_row(input logic [CMD_W-1:0] cmd,
            input logic [VAL_W-1:0] v, input logic [POS_W-1:0] pos,
            input logic typed, input t_list_result res);
        t_list_row row;
        row.cmd   = cmd;
        row.value = v;
        row.pos   = pos;
        row.typed = typed;
        row.res   = res;
        return row;
    endfunction

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] v,
            input logic [POS_W-1:0] pos, input int gap, input bit typed,
            input t_list_result want);
        t_list_result predicted;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_value    <= v;
        i_position <= pos;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = apply_to_shadow(cmd, v, pos);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic check_field(input string name, input logic [VAL_W-1:0] want,
            input logic [VAL_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 'h%0h, actual 'h%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, o_status);
                check_field("read_value", want.read_value, o_read_value);
                check_field("found", want.found, o_found);
                check_field("count", want.count, o_count);
                check_field("full_res", want.full_res, o_full_res);
                check_field("empty_res", want.empty_res, o_empty_res);
            end
        end
    end

    // result side: random hold-off before each result, none in calm stretches
    initial begin
        int hold;
        forever begin
            hold = rx_calm ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (o_valid !== 1'b1) @(posedge i_clk);
        end
    end

    initial begin
        t_list_row        dir_rows [$];
        t_list_row        row;
        t_list_result     none;
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] v;
        logic [POS_W-1:0] pos;
        int               blk;
        int               n;
        int               roll;
        int               flavour;
        int               t_ins, t_rem, t_get, t_find, t_clr;
        bit               tx_calm;

        none = '0;
        // empty list first: get, remove and find all have nothing to work on
        dir_rows.push_back(mk_row(CMD_GET, '0, 4'd0, 1'b1, typed_res(ST_BADPOS, READ_MISS, 0, 0)));
        dir_rows.push_back(mk_row(CMD_REMOVE, 32'd5, '0, 1'b1, typed_res(ST_EMPTY, '0, 0, 0)));
        dir_rows.push_back(mk_row(CMD_FIND, '0, '0, 1'b1, typed_res(ST_OK, '0, 0, 0)));
        dir_rows.push_back(mk_row(CMD_INSERT, VAL_MAX, '0, 1'b1, typed_res(ST_OK, '0, 0, 1)));
        dir_rows.push_back(mk_row(CMD_INSERT, VAL_MIN, '0, 1'b1, typed_res(ST_OK, '0, 0, 2)));
        dir_rows.push_back(mk_row(CMD_GET, '0, 4'd0, 1'b1, typed_res(ST_OK, VAL_MIN, 0, 2)));
        dir_rows.push_back(mk_row(CMD_GET, '0, 4'd1, 1'b1, typed_res(ST_OK, VAL_MAX, 0, 2)));
        // fill to capacity, with duplicates and near-extremes
        dir_rows.push_back(mk_row(CMD_INSERT, 32'd0, '0, 1'b0, none));
        dir_rows.push_back(mk_row(CMD_INSERT, 32'd0, '0, 1'b0, none));
        dir_rows.push_back(mk_row(CMD_INSERT, -32'sd1, '0, 1'b0, none));
        dir_rows.push_back(mk_row(CMD_INSERT, 32'd3, '0, 1'b0, none));
        dir_rows.push_back(mk_row(CMD_INSERT, -32'sd7, '0, 1'b0, none));
        dir_rows.push_back(mk_row(CMD_INSERT, 32'd100, '0, 1'b0, none));
        dir_rows.push_back(mk_row(CMD_INSERT, 32'h1234_5678, '0, 1'b0, none));
        dir_rows.push_back(mk_row(CMD_INSERT, -32'sd100000, '0, 1'b0, none));
        dir_rows.push_back(mk_row(CMD_INSERT, 32'd2, '0, 1'b0, none));
        dir_rows.push_back(mk_row(CMD_INSERT, 32'd2, '0, 1'b0, none));
        dir_rows.push_back(mk_row(CMD_INSERT, 32'h7FFF_FFFE, '0, 1'b0, none));
        dir_rows.push_back(mk_row(CMD_INSERT, 32'h8000_0001, '0, 1'b0, none));
        dir_rows.push_back(mk_row(CMD_INSERT, 32'd55, '0, 1'b0, none));
        dir_rows.push_back(mk_row(CMD_INSERT, 32'd9, '0, 1'b0, none));
        dir_rows.push_back(mk_row(CMD_INSERT, 32'd1, '0, 1'b1,
            typed_res(ST_FULL, '0, 0, LIST_CAP)));
        dir_rows.push_back(mk_row(CMD_GET, '0, 4'd15, 1'b1,
            typed_res(ST_OK, VAL_MAX, 0, LIST_CAP)));
        dir_rows.push_back(mk_row(CMD_FIND, 32'h1234_5678, '0, 1'b0, none));
        dir_rows.push_back(mk_row(CMD_REMOVE, 32'd4, '0, 1'b1,
            typed_res(ST_NOTFOUND, '0, 0, LIST_CAP)));
        dir_rows.push_back(mk_row(CMD_REMOVE, 32'd0, '0, 1'b0, none));
        dir_rows.push_back(mk_row(CMD_REMOVE, VAL_MAX, '0, 1'b0, none));
        dir_rows.push_back(mk_row(CMD_UNUSED_LO, 32'd2, 4'd3, 1'b0, none));
        dir_rows.push_back(mk_row(CMD_UNUSED_HI, VAL_MIN, 4'd15, 1'b0, none));
        dir_rows.push_back(mk_row(CMD_CLEAR, '0, '0, 1'b1, typed_res(ST_OK, '0, 0, 0)));
        dir_rows.push_back(mk_row(CMD_GET, '0, 4'd0, 1'b1, typed_res(ST_BADPOS, READ_MISS, 0, 0)));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_request(row.cmd, row.value, row.pos, $urandom_range(0, MAX_IDLE),
                row.typed, row.res);
        end

        for (blk = 0; blk < RAND_BLOCKS; blk++) begin
            flavour = $urandom_range(0, 2);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            // every few blocks let the engine drain completely before carrying on
            if (blk % 6 == 3) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            case (flavour)
                0: begin
                    t_ins = 65; t_rem = 75; t_get = 85; t_find = 95; t_clr = 97;
                end
                1: begin
                    t_ins = 20; t_rem = 65; t_get = 78; t_find = 90; t_clr = 93;
                end
                default: begin
                    t_ins = 40; t_rem = 65; t_get = 80; t_find = 93; t_clr = 96;
                end
            endcase
            for (n = 0; n < BLOCK_LEN; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < t_ins) cmd = CMD_INSERT;
                else if (roll < t_rem) cmd = CMD_REMOVE;
                else if (roll < t_get) cmd = CMD_GET;
                else if (roll < t_find) cmd = CMD_FIND;
                else if (roll < t_clr) cmd = CMD_CLEAR;
                else cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));

                // values already held make removes and finds hit and inserts duplicate
                roll = $urandom_range(0, 99);
                if (roll < 40 && shadow_cnt > 0) begin
                    v = shadow_list[$urandom_range(0, shadow_cnt - 1)];
                end else if (roll < 65) begin
                    v = $urandom_range(0, 8) - 4;
                end else if (roll < 80) begin
                    case ($urandom_range(0, 3))
                        0: v = VAL_MIN;
                        1: v = VAL_MAX;
                        2: v = '0;
                        default: v = READ_MISS;
                    endcase
                end else begin
                    v = $urandom;
                end

                if (shadow_cnt > 0 && $urandom_range(0, 1) == 1)
                    pos = POS_W'($urandom_range(0, shadow_cnt - 1));
                else
                    pos = POS_W'($urandom_range(0, LIST_CAP - 1));

                send_request(cmd, v, pos, tx_calm ? 0 : $urandom_range(0, MAX_IDLE), 1'b0, none);
            end
        end

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("tb_sorted_list_engine: PASS");
        else
            $display("tb_sorted_list_engine: FAIL");
        $finish;
    end

endmodule
